FILE: hdl/utc_calendar_to_epoch_seconds_core_assert.svh
// assertion macros for the calendar to epoch seconds core
// expects clk and rst_n in the scope where the macros are used
`ifndef UTC_CALENDAR_TO_EPOCH_SECONDS_CORE_ASSERT_SVH
`define UTC_CALENDAR_TO_EPOCH_SECONDS_CORE_ASSERT_SVH

// same-cycle implication
`define UTC2E_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("utc2e assertion failed");

// next-cycle implication
`define UTC2E_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("utc2e assertion failed");

`endif

FILE: hdl/utc2e_pkg.sv
// shared types, constants and table functions for the calendar to epoch core
// no dependencies
package utc2e_pkg;

    localparam int unsigned ACC_W = 34;

    localparam logic [ACC_W-1:0] SECS_PER_YEAR = 34'd31536000;
    localparam logic [ACC_W-1:0] SECS_PER_DAY  = 34'd86400;
    localparam logic [ACC_W-1:0] SECS_PER_HOUR = 34'd3600;
    localparam logic [ACC_W-1:0] SECS_PER_MIN  = 34'd60;

    localparam logic [7:0] EPOCH_YEAR   = 8'd70;
    localparam logic [7:0] LAST_PRE_EPOCH = 8'd69;
    localparam logic [7:0] YEAR_1900    = 8'd0;
    localparam logic [7:0] YEAR_2100    = 8'd200;
    localparam logic [3:0] MONTH_FEB    = 4'd1;

    typedef struct packed {
        logic             sub;
        logic [ACC_W-1:0] operand;
    } alu_op_t;

    // gregorian rule on years since 1900: 1900 and 2100 are not leap, 2000 is
    function automatic logic leap_year(input logic [7:0] y);
        return (y[1:0] == 2'b00) && (y != YEAR_1900) && (y != YEAR_2100);
    endfunction

    function automatic logic [ACC_W-1:0] year_secs(input logic [7:0] y);
        return leap_year(y) ? (SECS_PER_YEAR + SECS_PER_DAY) : SECS_PER_YEAR;
    endfunction

    // seconds before each month, months past december saturate
    function automatic logic [ACC_W-1:0] month_start_secs(input logic [3:0] m);
        logic [ACC_W-1:0] s;
        case (m)
            4'd0:    s = 34'd0;
            4'd1:    s = 34'd2678400;
            4'd2:    s = 34'd5097600;
            4'd3:    s = 34'd7776000;
            4'd4:    s = 34'd10368000;
            4'd5:    s = 34'd13046400;
            4'd6:    s = 34'd15638400;
            4'd7:    s = 34'd18316800;
            4'd8:    s = 34'd20995200;
            4'd9:    s = 34'd23587200;
            4'd10:   s = 34'd26265600;
            default: s = 34'd28857600;
        endcase
        return s;
    endfunction

endpackage

FILE: hdl/utc2e_alu.sv
// shared add/subtract unit for the epoch seconds accumulator
// depends on utc2e_pkg
module utc2e_alu
    import utc2e_pkg::*;
(
    input  logic [ACC_W-1:0] acc,
    input  alu_op_t          op,
    output logic [ACC_W-1:0] sum
);

    always_comb
    begin
        if (op.sub)
        begin
            sum = acc - op.operand;
        end
        else
        begin
            sum = acc + op.operand;
        end
    end

endmodule

FILE: hdl/utc_calendar_to_epoch_seconds_core.sv
// top level: utc calendar time to signed unix epoch seconds
// depends on utc2e_pkg, utc2e_alu and the assertion macro header
//
// usage
//   a request is taken at a rising edge with start high and busy low; the
//   calendar fields are sampled at that edge. busy stays high while the
//   request is worked on and no new request is taken.
//   done is high for exactly one cycle with the result on epoch_seconds;
//   the receiver cannot stall it, so it must take it in that cycle.
// operation
//   one shared 34-bit add/subtract unit walks the years between the given
//   year and 1970 at one year per cycle, then adds month, leap day, day,
//   hour, minute and second in turn, each in a state of its own.
//   done and the result are registered from the final, second step; busy
//   falls in the cycle done is shown, so a new request may be taken in
//   that same cycle.
// reset
//   rst_n low clears the sequencer to idle and drops busy and done at once;
//   a request in progress is lost.
`include "utc_calendar_to_epoch_seconds_core_assert.svh"
module utc_calendar_to_epoch_seconds_core
    import utc2e_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [7:0]         year_since_1900,
    input  logic [3:0]         month_index,
    input  logic [4:0]         day_of_month,
    input  logic [4:0]         hour_of_day,
    input  logic [5:0]         minute_of_hour,
    input  logic [5:0]         second_of_minute,
    output logic               done,
    output logic signed [33:0] epoch_seconds
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_YEAR,
        ST_MONTH,
        ST_LEAP,
        ST_DAY,
        ST_HOUR,
        ST_MIN,
        ST_SEC
    } state_t;

    state_t           state_reg, state_next;
    logic [ACC_W-1:0] acc_reg, acc_next;
    logic [7:0]       y_reg, y_next;
    logic [7:0]       y_end_reg, y_end_next;
    logic             sub_reg, sub_next;
    logic [7:0]       year_reg, year_next;
    logic [3:0]       mon_reg, mon_next;
    logic [4:0]       day_reg, day_next;
    logic [4:0]       hour_reg, hour_next;
    logic [5:0]       min_reg, min_next;
    logic [5:0]       sec_reg, sec_next;
    logic             done_reg, done_next;
    logic [ACC_W-1:0] result_reg, result_next;

    alu_op_t          alu_op;
    logic [ACC_W-1:0] alu_sum;
    logic             accept;

    assign accept = start && (state_reg == ST_IDLE);

    utc2e_alu u_alu (
        .acc     (acc_reg),
        .op      (alu_op),
        .sum     (alu_sum)
    );

    always_comb
    begin
        state_next  = state_reg;
        acc_next    = acc_reg;
        y_next      = y_reg;
        y_end_next  = y_end_reg;
        sub_next    = sub_reg;
        year_next   = year_reg;
        mon_next    = mon_reg;
        day_next    = day_reg;
        hour_next   = hour_reg;
        min_next    = min_reg;
        sec_next    = sec_reg;
        done_next   = 1'b0;
        result_next = result_reg;
        alu_op.sub     = 1'b0;
        alu_op.operand = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    year_next = year_since_1900;
                    mon_next  = month_index;
                    day_next  = day_of_month;
                    hour_next = hour_of_day;
                    min_next  = minute_of_hour;
                    sec_next  = second_of_minute;
                    // days count from the first, so start one day down
                    acc_next  = '0 - SECS_PER_DAY;
                    if (year_since_1900 < EPOCH_YEAR)
                    begin
                        sub_next   = 1'b1;
                        y_next     = year_since_1900;
                        y_end_next = EPOCH_YEAR;
                    end
                    else
                    begin
                        sub_next   = 1'b0;
                        y_next     = EPOCH_YEAR;
                        y_end_next = year_since_1900;
                    end
                    state_next = ST_YEAR;
                end
            end
            ST_YEAR:
            begin
                alu_op.sub     = sub_reg;
                alu_op.operand = year_secs(y_reg);
                if (y_reg == y_end_reg)
                begin
                    state_next = ST_MONTH;
                end
                else
                begin
                    acc_next = alu_sum;
                    y_next   = y_reg + 8'd1;
                end
            end
            ST_MONTH:
            begin
                alu_op.operand = month_start_secs(mon_reg);
                acc_next       = alu_sum;
                state_next     = ST_LEAP;
            end
            ST_LEAP:
            begin
                // leap day only after february, saturated months count as december
                alu_op.operand = ((mon_reg > MONTH_FEB) && leap_year(year_reg)) ?
                                 SECS_PER_DAY : '0;
                acc_next       = alu_sum;
                state_next     = ST_DAY;
            end
            ST_DAY:
            begin
                alu_op.operand = ACC_W'(day_reg) * SECS_PER_DAY;
                acc_next       = alu_sum;
                state_next     = ST_HOUR;
            end
            ST_HOUR:
            begin
                alu_op.operand = ACC_W'(hour_reg) * SECS_PER_HOUR;
                acc_next       = alu_sum;
                state_next     = ST_MIN;
            end
            ST_MIN:
            begin
                alu_op.operand = ACC_W'(min_reg) * SECS_PER_MIN;
                acc_next       = alu_sum;
                state_next     = ST_SEC;
            end
            ST_SEC:
            begin
                alu_op.operand = ACC_W'(sec_reg);
                acc_next       = alu_sum;
                result_next    = alu_sum;
                done_next      = 1'b1;
                state_next     = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            acc_reg    <= '0;
            y_reg      <= '0;
            y_end_reg  <= '0;
            sub_reg    <= 1'b0;
            year_reg   <= '0;
            mon_reg    <= '0;
            day_reg    <= '0;
            hour_reg   <= '0;
            min_reg    <= '0;
            sec_reg    <= '0;
            done_reg   <= 1'b0;
            result_reg <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            acc_reg    <= acc_next;
            y_reg      <= y_next;
            y_end_reg  <= y_end_next;
            sub_reg    <= sub_next;
            year_reg   <= year_next;
            mon_reg    <= mon_next;
            day_reg    <= day_next;
            hour_reg   <= hour_next;
            min_reg    <= min_next;
            sec_reg    <= sec_next;
            done_reg   <= done_next;
            result_reg <= result_next;
        end
    end

    assign busy          = (state_reg != ST_IDLE);
    assign done          = done_reg;
    assign epoch_seconds = result_reg;

    `UTC2E_ASSERT_NEXT(a_accept_goes_busy, start && !busy, busy)
    `UTC2E_ASSERT_SAME(a_done_when_idle, done, !busy)
    `UTC2E_ASSERT_NEXT(a_done_single, done, !done)
    `UTC2E_ASSERT_SAME(a_year_walk_bounded, state_reg == ST_YEAR, y_reg <= y_end_reg)

endmodule

FILE: dv/tb_utc_calendar_to_epoch_seconds_core.sv
// testbench for utc_calendar_to_epoch_seconds_core: directed and random calendar requests,
// each result checked against an epoch seconds predictor held in the bench
// depends on utc2e_pkg and the core rtl
module tb_utc_calendar_to_epoch_seconds_core;
    import utc2e_pkg::*;

    typedef struct packed {
        logic [7:0] year;
        logic [3:0] mon;
        logic [4:0] day;
        logic [4:0] hour;
        logic [5:0] minute;
        logic [5:0] sec;
        logic [2:0] gap;
        logic       drain;
    } cal_req_t;

    localparam longint DAY_SECS   = 86400;
    localparam int     EPOCH_BASE = 70;

    logic               clk;
    logic               rst_n            = 1'b0;
    logic               start            = 1'b0;
    logic               busy;
    logic [7:0]         year_since_1900  = '0;
    logic [3:0]         month_index      = '0;
    logic [4:0]         day_of_month     = '0;
    logic [4:0]         hour_of_day      = '0;
    logic [5:0]         minute_of_hour   = '0;
    logic [5:0]         second_of_minute = '0;
    logic               done;
    logic signed [33:0] epoch_seconds;

    cal_req_t           pending_q[$];
    logic signed [33:0] epoch_expect_q[$];
    cal_req_t           cur;
    bit                 holding   = 1'b0;
    bit                 req_taken = 1'b0;
    int                 gap_count = 0;
    int                 err_count = 0;

    utc_calendar_to_epoch_seconds_core u_dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .start            (start),
        .busy             (busy),
        .year_since_1900  (year_since_1900),
        .month_index      (month_index),
        .day_of_month     (day_of_month),
        .hour_of_day      (hour_of_day),
        .minute_of_hour   (minute_of_hour),
        .second_of_minute (second_of_minute),
        .done             (done),
        .epoch_seconds    (epoch_seconds)
    );

    function automatic bit is_leap(input int y);
        return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 100));
    endfunction

    function automatic int month_days(input int m, input bit leap);
        int d;
        case (m)
            1:       d = leap ? 29 : 28;
            3, 5, 8, 10: d = 30;
            default: d = 31;
        endcase
        return d;
    endfunction

    function automatic logic signed [33:0] calc_epoch(input cal_req_t r);
        longint t;
        int     y;
        int     m;
        int     k;
        t = 0;
        y = int'(r.year);
        if (y > EPOCH_BASE)
        begin
            for (k = EPOCH_BASE; k < y; k++)
                t += longint'(365 + is_leap(k)) * DAY_SECS;
        end
        else
        begin
            for (k = y; k < EPOCH_BASE; k++)
                t -= longint'(365 + is_leap(k)) * DAY_SECS;
        end
        // months past december count as december
        m = (r.mon > 4'd11) ? 11 : int'(r.mon);
        for (k = 0; k < m; k++)
            t += longint'(month_days(k, is_leap(y))) * DAY_SECS;
        t += (((longint'(r.day) - 1) * 24 + r.hour) * 60 + r.minute) * 60 + r.sec;
        return t[33:0];
    endfunction

    task automatic add_req(input int y, input int mo, input int d, input int h, input int mi,
                           input int s, input int gap, input bit drain);
        cal_req_t r;
        r.year   = 8'(y);
        r.mon    = 4'(mo);
        r.day    = 5'(d);
        r.hour   = 5'(h);
        r.minute = 6'(mi);
        r.sec    = 6'(s);
        r.gap    = 3'(gap);
        r.drain  = drain;
        pending_q.push_back(r);
    endtask

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // request driver
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (req_taken)
            begin
                req_taken = 1'b0;
                holding   = 1'b0;
                gap_count = 0;
            end
            if (!holding && pending_q.size() != 0)
            begin
                if (gap_count < pending_q[0].gap)
                    gap_count++;
                else if (!pending_q[0].drain || epoch_expect_q.size() == 0)
                begin
                    cur = pending_q.pop_front();
                    year_since_1900  <= cur.year;
                    month_index      <= cur.mon;
                    day_of_month     <= cur.day;
                    hour_of_day      <= cur.hour;
                    minute_of_hour   <= cur.minute;
                    second_of_minute <= cur.sec;
                    holding = 1'b1;
                end
            end
            start <= holding;
        end
    end

    // request and result monitor
    always @(posedge clk)
    begin
        cal_req_t           seen;
        logic signed [33:0] want;
        if (rst_n)
        begin
            if (start && !busy)
            begin
                seen        = '0;
                seen.year   = year_since_1900;
                seen.mon    = month_index;
                seen.day    = day_of_month;
                seen.hour   = hour_of_day;
                seen.minute = minute_of_hour;
                seen.sec    = second_of_minute;
                epoch_expect_q.push_back(calc_epoch(seen));
                req_taken = 1'b1;
            end
            if (done)
            begin
                if (epoch_expect_q.size() == 0)
                begin
                    $error("epoch_seconds: unexpected result, actual %0d", epoch_seconds);
                    err_count++;
                end
                else
                begin
                    want = epoch_expect_q.pop_front();
                    if (epoch_seconds !== want)
                    begin
                        $error("epoch_seconds: expected %0d actual %0d", want, epoch_seconds);
                        err_count++;
                    end
                end
            end
        end
    end

    initial
    begin
        bit calm;
        int n;
        int mo;
        int h;
        int y;

        // extremes and special cases
        add_req(0, 0, 1, 0, 0, 0, 0, 0);
        add_req(255, 15, 31, 31, 63, 63, 0, 0);
        add_req(70, 0, 1, 0, 0, 0, 1, 0);
        add_req(69, 11, 31, 23, 59, 59, 0, 0);
        add_req(71, 0, 1, 0, 0, 0, 2, 0);
        add_req(100, 1, 29, 12, 0, 0, 0, 0);
        add_req(100, 2, 1, 0, 0, 0, 0, 0);
        add_req(200, 2, 1, 0, 0, 0, 3, 0);
        add_req(0, 2, 1, 0, 0, 0, 0, 0);
        add_req(104, 12, 1, 0, 0, 0, 0, 0);
        add_req(104, 15, 31, 0, 0, 0, 4, 0);
        add_req(103, 13, 1, 0, 0, 0, 0, 0);
        add_req(70, 0, 0, 0, 0, 0, 0, 1);
        add_req(70, 0, 31, 23, 59, 60, 0, 0);
        add_req(130, 5, 15, 31, 63, 63, 1, 0);
        add_req(255, 0, 1, 0, 0, 0, 0, 0);
        add_req(68, 1, 29, 0, 0, 0, 0, 0);
        add_req(72, 2, 1, 0, 0, 0, 0, 0);
        add_req(69, 0, 1, 0, 0, 0, 0, 0);
        add_req(254, 11, 31, 23, 59, 60, 2, 0);
        add_req(0, 15, 0, 31, 63, 63, 0, 0);
        add_req(199, 14, 16, 17, 42, 21, 0, 0);

        // random requests in stretches, some with no idling
        calm = 1'b0;
        for (n = 0; n < 1500; n++)
        begin
            if (n % 100 == 0)
                calm = ($urandom_range(0, 3) == 0);
            y  = ($urandom_range(0, 4) == 0) ? $urandom_range(60, 80) : $urandom_range(0, 255);
            mo = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 15) : $urandom_range(0, 11);
            h  = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 31) : $urandom_range(0, 23);
            add_req(y, mo, $urandom_range(0, 31), h, $urandom_range(0, 63),
                    $urandom_range(0, 63), calm ? 0 : $urandom_range(0, 4),
                    (n % 250 == 125));
        end

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (pending_q.size() != 0 || holding)
            @(posedge clk);
        while (epoch_expect_q.size() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
        if (epoch_expect_q.size() != 0)
        begin
            $error("epoch_seconds: %0d expected results never arrived", epoch_expect_q.size());
            err_count++;
        end
        if (err_count == 0)
            $display("tb_utc_calendar_to_epoch_seconds_core: clean");
        else
            $display("tb_utc_calendar_to_epoch_seconds_core: errors");
        $finish;
    end

    initial
    begin
        #40000000;
        $display("tb_utc_calendar_to_epoch_seconds_core: errors");
        $finish;
    end

endmodule
